@@ rtl/tqnw_pkg.sv @@
// shared types and constants for the terrain cell normal pipeline
// no dependencies; used by the interfaces, tqnw_norm and the top level
package tqnw_pkg;

   localparam int HGT_W   = 16;  // Q8.8 height
   localparam int GRID_W  = 15;  // unsigned Q7.8 spacing
   localparam int DIFF_W  = 17;  // exact height difference
   localparam int SQ_W    = 34;  // squares and squared norm
   localparam int QUO_W   = 31;  // floor(v2 * 2^30 / s)
   localparam int ROOT_W  = 16;  // isqrt of the quotient
   localparam int MAG_W   = 15;  // Q1.14 magnitude, up to 1.0
   localparam int COMP_W  = 16;  // signed Q1.14 component
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam int DIV_STEPS  = 30;
   localparam int SQRT_STEPS = 16;
   // init, division steps, root steps, rounding
   localparam int UNIT_LAT   = 1 + DIV_STEPS + SQRT_STEPS + 1;
   localparam int FRONT_LAT  = 3;
   localparam int NSTG       = FRONT_LAT + UNIT_LAT;

   localparam logic [MAG_W-1:0]     ONE_Q14     = MAG_W'(16384);
   localparam logic [GRID_W-1:0]    GRID_RESET  = GRID_W'(256);
   localparam logic [HGT_W-1:0]     SEA_RESET   = '0;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SPACING = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WATER_LINE   = 1'b1;

   typedef struct packed {
      logic neg_x1;
      logic neg_z1;
      logic neg_x2;
      logic neg_z2;
      logic deg1;
      logic deg2;
      logic water;
   } side_type;

endpackage

@@ rtl/tqnw_if.sv @@
// valid/ready channel interfaces for cell corner heights and cell normals
// depends on tqnw_pkg for field widths
interface tqnw_req_if import tqnw_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [HGT_W-1:0]  height_00;
   logic signed [HGT_W-1:0]  height_01;
   logic signed [HGT_W-1:0]  height_10;
   logic signed [HGT_W-1:0]  height_11;

   modport source (output valid, height_00, height_01, height_10, height_11,
                   input ready);
   modport sink   (input valid, height_00, height_01, height_10, height_11,
                   output ready);
endinterface

interface tqnw_rsp_if import tqnw_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COMP_W-1:0] first_nx;
   logic        [MAG_W-1:0]  first_ny;
   logic signed [COMP_W-1:0] first_nz;
   logic signed [COMP_W-1:0] second_nx;
   logic        [MAG_W-1:0]  second_ny;
   logic signed [COMP_W-1:0] second_nz;
   logic                     is_water;

   modport source (output valid, first_nx, first_ny, first_nz, second_nx,
                   second_ny, second_nz, is_water, input ready);
   modport sink   (input valid, first_nx, first_ny, first_nz, second_nx,
                   second_ny, second_nz, is_water, output ready);
endinterface

@@ rtl/terrain_quad_normals_water.sv @@
// top level: heightfield cell face normals and water mark
// depends on tqnw_pkg, tqnw_if (channel interfaces) and tqnw_norm
//
// usage:
//   req_ch carries the four corner heights of one grid cell (signed Q8.8);
//   rsp_ch returns both triangle unit normals (Q1.14) and the water flag,
//   one result item for every request item, in order.
//   csr_we/csr_index/csr_wdata write grid_spacing (index 0) and the water
//   line (index 1); write them only while no item is in flight.
// pipeline: 3 front stages for differences, squares and norm sum, then
//   48 stages per component: 31 divide steps, 16 root steps and a
//   rounding stage.
// throughput: one item per cycle when not stalled; every stage holds one item.
// reset: clears all stage valid bits and loads spacing 1.0, sea level 0.
// stall: when rsp_ch is held off, the whole pipeline freezes and req_ch.ready
//   drops; nothing is lost or repeated, and an empty output slot keeps the
//   pipeline moving.
module terrain_quad_normals_water import tqnw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tqnw_req_if.sink             req_ch,
   tqnw_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   logic                     adv;
   logic [NSTG-1:0]          vld_ff;
   logic [GRID_W-1:0]        grid_ff;
   logic signed [HGT_W-1:0]  sea_ff;

   // stage a: differences
   logic signed [DIFF_W-1:0] x1_ff, z1_ff, x2_ff, z2_ff;
   logic                     wat_a_ff;
   // stage b: squares
   logic signed [SQ_W-1:0]   x1s_in, z1s_in, x2s_in, z2s_in;
   logic [SQ_W-1:0]          x1s_ff, z1s_ff, x2s_ff, z2s_ff, ls_ff;
   logic [3:0]               neg_b_ff;
   logic                     wat_b_ff;
   // stage c: norms
   logic [SQ_W-1:0]          s1_ff, s2_ff;
   logic [SQ_W-1:0]          vx1_ff, vz1_ff, vx2_ff, vz2_ff, vl_ff;
   side_type                 side_ff [0:UNIT_LAT];

   logic [SQ_W-1:0]          s1_in, s2_in;
   logic [MAG_W-1:0]         m_x1, m_y1, m_z1, m_x2, m_y2, m_z2;
   side_type                 so;

   assign adv          = !vld_ff[NSTG-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= GRID_RESET;
         sea_ff  <= SEA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_SPACING: grid_ff <= csr_wdata[GRID_W-1:0];
            CSR_WATER_LINE:   sea_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff <= DIFF_W'(req_ch.height_00) - DIFF_W'(req_ch.height_10);
         z1_ff <= DIFF_W'(req_ch.height_00) - DIFF_W'(req_ch.height_01);
         x2_ff <= DIFF_W'(req_ch.height_01) - DIFF_W'(req_ch.height_11);
         z2_ff <= DIFF_W'(req_ch.height_10) - DIFF_W'(req_ch.height_11);
         wat_a_ff <= (req_ch.height_00 <= sea_ff) || (req_ch.height_01 <= sea_ff) ||
                     (req_ch.height_10 <= sea_ff) || (req_ch.height_11 <= sea_ff);
      end
   end

   // full-width signed products, never negative
   assign x1s_in = x1_ff * x1_ff;
   assign z1s_in = z1_ff * z1_ff;
   assign x2s_in = x2_ff * x2_ff;
   assign z2s_in = z2_ff * z2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x1s_ff   <= unsigned'(x1s_in);
         z1s_ff   <= unsigned'(z1s_in);
         x2s_ff   <= unsigned'(x2s_in);
         z2s_ff   <= unsigned'(z2s_in);
         ls_ff    <= SQ_W'(grid_ff) * SQ_W'(grid_ff);
         neg_b_ff <= {x1_ff[DIFF_W-1], z1_ff[DIFF_W-1], x2_ff[DIFF_W-1], z2_ff[DIFF_W-1]};
         wat_b_ff <= wat_a_ff;
      end
   end

   assign s1_in = x1s_ff + z1s_ff + ls_ff;
   assign s2_in = x2s_ff + z2s_ff + ls_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         vx1_ff <= x1s_ff;
         vz1_ff <= z1s_ff;
         vx2_ff <= x2s_ff;
         vz2_ff <= z2s_ff;
         vl_ff  <= ls_ff;
         side_ff[0] <= '{neg_x1: neg_b_ff[3], neg_z1: neg_b_ff[2],
                         neg_x2: neg_b_ff[1], neg_z2: neg_b_ff[0],
                         deg1: s1_in == '0, deg2: s2_in == '0,
                         water: wat_b_ff};
      end
   end

   for (genvar k = 0; k < UNIT_LAT; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   tqnw_norm u_x1 (.clock(clock), .adv(adv), .v2(vx1_ff), .s(s1_ff), .mag(m_x1));
   tqnw_norm u_y1 (.clock(clock), .adv(adv), .v2(vl_ff),  .s(s1_ff), .mag(m_y1));
   tqnw_norm u_z1 (.clock(clock), .adv(adv), .v2(vz1_ff), .s(s1_ff), .mag(m_z1));
   tqnw_norm u_x2 (.clock(clock), .adv(adv), .v2(vx2_ff), .s(s2_ff), .mag(m_x2));
   tqnw_norm u_y2 (.clock(clock), .adv(adv), .v2(vl_ff),  .s(s2_ff), .mag(m_y2));
   tqnw_norm u_z2 (.clock(clock), .adv(adv), .v2(vz2_ff), .s(s2_ff), .mag(m_z2));

   assign so = side_ff[UNIT_LAT];

   // flat cell with zero spacing points straight up
   assign rsp_ch.valid     = vld_ff[NSTG-1];
   assign rsp_ch.first_nx  = so.deg1 ? '0 :
                             (so.neg_x1 ? -COMP_W'(m_x1) : COMP_W'(m_x1));
   assign rsp_ch.first_ny  = so.deg1 ? ONE_Q14 : m_y1;
   assign rsp_ch.first_nz  = so.deg1 ? '0 :
                             (so.neg_z1 ? -COMP_W'(m_z1) : COMP_W'(m_z1));
   assign rsp_ch.second_nx = so.deg2 ? '0 :
                             (so.neg_x2 ? -COMP_W'(m_x2) : COMP_W'(m_x2));
   assign rsp_ch.second_ny = so.deg2 ? ONE_Q14 : m_y2;
   assign rsp_ch.second_nz = so.deg2 ? '0 :
                             (so.neg_z2 ? -COMP_W'(m_z2) : COMP_W'(m_z2));
   assign rsp_ch.is_water  = so.water;

endmodule

@@ rtl/tqnw_norm.sv @@
// one normal component magnitude: round(sqrt(v2 / s) * 2^14), clamped to 1.0
// pipelined restoring divide then bit-serial root; depends on tqnw_pkg
module tqnw_norm import tqnw_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  logic [SQ_W-1:0]   v2,
   input  logic [SQ_W-1:0]   s,
   output logic [MAG_W-1:0]  mag
);

   logic [SQ_W-1:0]   dr_ff [0:DIV_STEPS];
   logic [QUO_W-1:0]  dq_ff [0:DIV_STEPS];
   logic [SQ_W-1:0]   ds_ff [0:DIV_STEPS-1];

   logic [QUO_W-1:0]  rm_ff [1:SQRT_STEPS-1];
   logic [ROOT_W-1:0] rt_ff [1:SQRT_STEPS];
   logic [QUO_W-1:0]  rm_w  [0:SQRT_STEPS-1];
   logic [ROOT_W-1:0] rt_w  [0:SQRT_STEPS-1];

   logic [MAG_W-1:0]  mag_ff;
   logic [ROOT_W:0]   rnd;
   logic [ROOT_W-1:0] half;

   // v2 <= s, so only the top quotient bit can be set before shifting
   always_ff @(posedge clock) begin
      if (adv) begin
         dr_ff[0] <= (v2 >= s) ? v2 - s : v2;
         dq_ff[0] <= {{(QUO_W-1){1'b0}}, v2 >= s};
         ds_ff[0] <= s;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [SQ_W:0] sh;
      logic [SQ_W:0] df;
      logic          ge;
      assign sh = {dr_ff[k], 1'b0};
      assign df = sh - {1'b0, ds_ff[k]};
      assign ge = sh >= {1'b0, ds_ff[k]};
      always_ff @(posedge clock) begin
         if (adv) begin
            dr_ff[k+1] <= ge ? df[SQ_W-1:0] : sh[SQ_W-1:0];
            dq_ff[k+1] <= {dq_ff[k][QUO_W-2:0], ge};
         end
      end
      if (k < DIV_STEPS-1) begin : g_s
         always_ff @(posedge clock) begin
            if (adv) begin
               ds_ff[k+1] <= ds_ff[k];
            end
         end
      end
   end

   assign rm_w[0] = dq_ff[DIV_STEPS];
   assign rt_w[0] = '0;
   for (genvar j = 1; j < SQRT_STEPS; j++) begin : g_src
      assign rm_w[j] = rm_ff[j];
      assign rt_w[j] = rt_ff[j];
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam int I = SQRT_STEPS - 1 - j;
      logic [QUO_W+1:0] t;
      logic             ge;
      assign t  = ((QUO_W+2)'(rt_w[j]) << (I + 1)) + ((QUO_W+2)'(1) << (2 * I));
      assign ge = {2'b00, rm_w[j]} >= t;
      always_ff @(posedge clock) begin
         if (adv) begin
            rt_ff[j+1] <= ge ? (rt_w[j] | (ROOT_W'(1) << I)) : rt_w[j];
         end
      end
      if (j < SQRT_STEPS-1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rm_ff[j+1] <= ge ? rm_w[j] - t[QUO_W-1:0] : rm_w[j];
            end
         end
      end
   end

   // largest q with 2q-1 <= root
   assign rnd  = {1'b0, rt_ff[SQRT_STEPS]} + (ROOT_W+1)'(1);
   assign half = rnd[ROOT_W:1];

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= (half > ROOT_W'(ONE_Q14)) ? ONE_Q14 : half[MAG_W-1:0];
      end
   end

   assign mag = mag_ff;

endmodule

@@ tb/terrain_quad_normals_water_test.sv @@
// testbench for terrain_quad_normals_water: random and directed grid cells
// depends on tqnw_pkg and tqnw_if; predicts normals and water flag per cell
module terrain_quad_normals_water_test;
   import tqnw_pkg::*;

   typedef struct packed {
      logic signed [HGT_W-1:0] h00;
      logic signed [HGT_W-1:0] h01;
      logic signed [HGT_W-1:0] h10;
      logic signed [HGT_W-1:0] h11;
   } cell_type;

   typedef struct packed {
      logic [COMP_W-1:0] fx;
      logic [MAG_W-1:0]  fy;
      logic [COMP_W-1:0] fz;
      logic [COMP_W-1:0] sx;
      logic [MAG_W-1:0]  sy;
      logic [COMP_W-1:0] sz;
      logic              water;
   } normals_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   tqnw_req_if req_ch();
   tqnw_rsp_if rsp_ch();

   terrain_quad_normals_water dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   logic [GRID_W-1:0] spacing_model = GRID_RESET;
   logic [HGT_W-1:0]  sea_model = SEA_RESET;
   cell_type    pending_cells[$];
   normals_type expected_normals[$];
   int errors = 0;
   bit calm = 0;
   bit hold = 0;

   // round(|v| * 2^14 / sqrt(s)) by bitwise search, exact in integers
   function automatic logic [MAG_W-1:0] unit_mag(longint v, longint unsigned s);
      longint unsigned av, rhs, cand, t, q;
      av = (v < 0) ? -v : v;
      rhs = (av * av) << 30;
      q = 0;
      for (int b = 14; b >= 0; b--) begin
         cand = q | (64'd1 << b);
         if (cand <= 16384) begin
            t = 2 * cand - 1;
            if (t * t * s <= rhs) q = cand;
         end
      end
      return MAG_W'(q);
   endfunction

   function automatic logic [COMP_W-1:0] signed_comp(longint v, longint unsigned s);
      logic [COMP_W-1:0] m;
      m = COMP_W'(unit_mag(v, s));
      return (v < 0) ? -m : m;
   endfunction

   function automatic void face_normal(longint x, longint z, output logic [COMP_W-1:0] ox,
                                       output logic [MAG_W-1:0] oy,
                                       output logic [COMP_W-1:0] oz);
      longint unsigned l, s;
      l = spacing_model;
      s = x * x + z * z + l * l;
      if (s == 0) begin
         ox = '0; oy = ONE_Q14; oz = '0;
      end else begin
         ox = signed_comp(x, s);
         oy = unit_mag(l, s);
         oz = signed_comp(z, s);
      end
   endfunction

   function automatic normals_type cell_normals(cell_type c);
      normals_type r;
      longint a, b, cc, d, sl;
      a = longint'(c.h01) - c.h00;
      b = longint'(c.h10) - c.h00;
      cc = longint'(c.h10) - c.h11;
      d = longint'(c.h01) - c.h11;
      sl = longint'($signed(sea_model));
      face_normal(-b, -a, r.fx, r.fy, r.fz);
      face_normal(d, cc, r.sx, r.sy, r.sz);
      r.water = (c.h00 <= sl) || (c.h01 <= sl) || (c.h10 <= sl) || (c.h11 <= sl);
      return r;
   endfunction

   // driver
   initial begin
      req_ch.valid = 0;
      req_ch.height_00 = '0; req_ch.height_01 = '0;
      req_ch.height_10 = '0; req_ch.height_11 = '0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_normals.push_back(cell_normals({req_ch.height_00, req_ch.height_01,
                                                     req_ch.height_10, req_ch.height_11}));
            void'(pending_cells.pop_front());
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (!hold && pending_cells.size() != 0 &&
                (calm || $urandom_range(99) >= 14)) begin
               req_ch.valid <= 1;
               req_ch.height_00 <= pending_cells[0].h00;
               req_ch.height_01 <= pending_cells[0].h01;
               req_ch.height_10 <= pending_cells[0].h10;
               req_ch.height_11 <= pending_cells[0].h11;
            end else begin
               req_ch.valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      normals_type e;
      if (reset) begin
         rsp_ch.ready <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_normals.size() == 0) begin
               $error("unexpected result item");
               errors++;
            end else begin
               e = expected_normals.pop_front();
               if (rsp_ch.first_nx !== e.fx) begin
                  $error("first_nx expected %0d actual %0d", $signed(e.fx), rsp_ch.first_nx);
                  errors++;
               end
               if (rsp_ch.first_ny !== e.fy) begin
                  $error("first_ny expected %0d actual %0d", e.fy, rsp_ch.first_ny);
                  errors++;
               end
               if (rsp_ch.first_nz !== e.fz) begin
                  $error("first_nz expected %0d actual %0d", $signed(e.fz), rsp_ch.first_nz);
                  errors++;
               end
               if (rsp_ch.second_nx !== e.sx) begin
                  $error("second_nx expected %0d actual %0d", $signed(e.sx),
                         rsp_ch.second_nx);
                  errors++;
               end
               if (rsp_ch.second_ny !== e.sy) begin
                  $error("second_ny expected %0d actual %0d", e.sy, rsp_ch.second_ny);
                  errors++;
               end
               if (rsp_ch.second_nz !== e.sz) begin
                  $error("second_nz expected %0d actual %0d", $signed(e.sz),
                         rsp_ch.second_nz);
                  errors++;
               end
               if (rsp_ch.is_water !== e.water) begin
                  $error("is_water expected %0d actual %0d", e.water, rsp_ch.is_water);
                  errors++;
               end
            end
         end
         rsp_ch.ready <= calm || $urandom_range(99) >= 14;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == CSR_GRID_SPACING) spacing_model = val[GRID_W-1:0];
      else sea_model = val;
   endtask

   task automatic drain;
      while (pending_cells.size() != 0 || expected_normals.size() != 0) @(posedge clock);
      repeat (NSTG + 5) @(posedge clock);
   endtask

   function automatic logic [HGT_W-1:0] rand_height();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return HGT_W'($urandom_range(511)) - 16'd256;
         default: return HGT_W'($urandom);
      endcase
   endfunction

   task automatic add_random(int n);
      cell_type c;
      logic [HGT_W-1:0] base;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(2) == 0) begin
            // gentle terrain near one base height
            base = HGT_W'($urandom);
            c.h00 = base + HGT_W'($urandom_range(1023)) - 16'd512;
            c.h01 = base + HGT_W'($urandom_range(1023)) - 16'd512;
            c.h10 = base + HGT_W'($urandom_range(1023)) - 16'd512;
            c.h11 = base + HGT_W'($urandom_range(1023)) - 16'd512;
         end else begin
            c = {rand_height(), rand_height(), rand_height(), rand_height()};
         end
         pending_cells.push_back(c);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      // directed cells at reset settings
      pending_cells.push_back({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
      pending_cells.push_back({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
      pending_cells.push_back({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
      pending_cells.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      pending_cells.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      pending_cells.push_back({16'sh0001, 16'sh0001, 16'sh0001, 16'sh0000});
      pending_cells.push_back({16'sh0100, 16'sh0000, 16'sh0200, 16'shff00});
      pending_cells.push_back({16'shffff, 16'sh0001, 16'sh0001, 16'sh0001});
      drain();
      // zero spacing: flat cell gives the degenerate straight-up normal
      write_reg(CSR_GRID_SPACING, 16'd0);
      write_reg(CSR_WATER_LINE, 16'h8000);
      pending_cells.push_back({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
      pending_cells.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      pending_cells.push_back({16'sh0010, 16'sh0010, 16'sh0020, 16'sh0020});
      pending_cells.push_back({16'sh7fff, 16'sh8000, 16'sh0000, 16'sh1234});
      drain();
      write_reg(CSR_GRID_SPACING, 16'h7fff);
      write_reg(CSR_WATER_LINE, 16'h7fff);
      pending_cells.push_back({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
      pending_cells.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
      pending_cells.push_back({16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
      // random cells at the largest spacing and water line
      add_random(300);
      drain();
      write_reg(CSR_GRID_SPACING, 16'd1);
      write_reg(CSR_WATER_LINE, 16'h0000);
      add_random(300);
      drain();
      write_reg(CSR_GRID_SPACING, 16'h8100);  // top bit lies outside the register
      write_reg(CSR_WATER_LINE, HGT_W'($urandom));
      calm = 1;
      add_random(400);
      drain();
      calm = 0;
      write_reg(CSR_GRID_SPACING, HGT_W'($urandom_range(32767, 1)));
      write_reg(CSR_WATER_LINE, 16'hff00);
      add_random(300);
      // sender waits until everything has come back
      while (pending_cells.size() > 150) @(posedge clock);
      hold = 1;
      while (expected_normals.size() != 0 || req_ch.valid) @(posedge clock);
      hold = 0;
      drain();
      write_reg(CSR_GRID_SPACING, GRID_RESET);
      write_reg(CSR_WATER_LINE, SEA_RESET);
      add_random(330);
      drain();
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #200000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
